@@ rtl/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// pee_pkg
// Shared constants and types of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_DIVZERO   = 2'd3;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_POW
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} alu_rsp_t;

endpackage

@@ rtl/pee_if.sv @@
// ----------------------------------------------------------------------------
// pee_if
// Valid/ready channels: expression characters in, results out.
// ----------------------------------------------------------------------------
interface pee_expr_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_expr;

	modport source (output valid, output ch, output end_of_expr, input ready);
	modport sink   (input valid, input ch, input end_of_expr, output ready);
endinterface

interface pee_result_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] value;
	logic        [1:0] status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/pee_stack.sv @@
// ----------------------------------------------------------------------------
// pee_stack
// Operand stack storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pee_stack
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
	input  logic [WORD_W-1:0]              wdata,
	input  logic [$clog2(STACK_DEPTH)-1:0] raddr_a,
	input  logic [$clog2(STACK_DEPTH)-1:0] raddr_b,
	output logic [WORD_W-1:0]              rdata_a,
	output logic [WORD_W-1:0]              rdata_b
);

	logic [WORD_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/pee_alu.sv @@
// ----------------------------------------------------------------------------
// pee_alu
// Operator unit: add/sub/mul finish straight from idle; radix-2 divide and
// square-and-multiply power run as iterative loops.
// ----------------------------------------------------------------------------
module pee_alu
	import pee_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output alu_rsp_t          rsp,
	output logic [WORD_W-1:0] res
);

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_POW
	} alu_state_t;

	alu_state_t        state_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] opd_q;
	logic [WORD_W-1:0] ex_q;
	logic [WORD_W-1:0] rem_q;
	logic [4:0]        step_q;
	logic              neg_q;
	logic              done_q;
	logic              dz_q;
	logic [WORD_W-1:0] res_q;

	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic [WORD_W-1:0] mul_ab;
	logic [WORD_W-1:0] mul_acc;
	logic [WORD_W-1:0] mul_sq;
	logic [WORD_W:0]   rem_sh;
	logic              ge;
	logic [WORD_W:0]   rem_diff;
	logic [WORD_W-1:0] rem_n;
	logic [WORD_W-1:0] quo_n;

	assign mag_a   = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
	assign mag_b   = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
	assign mul_ab  = a * b;
	assign mul_acc = acc_q * opd_q;
	assign mul_sq  = opd_q * opd_q;

	assign rem_sh   = {rem_q, acc_q[WORD_W-1]};
	assign ge       = rem_sh >= {1'b0, opd_q};
	assign rem_diff = rem_sh - {1'b0, opd_q};
	assign rem_n    = ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
	assign quo_n    = {acc_q[WORD_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			acc_q   <= '0;
			opd_q   <= '0;
			ex_q    <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						dz_q <= 1'b0;
						case (req.op)
							OP_ADD: begin
								res_q  <= a + b;
								done_q <= 1'b1;
							end
							OP_SUB: begin
								res_q  <= a - b;
								done_q <= 1'b1;
							end
							OP_MUL: begin
								res_q  <= mul_ab;
								done_q <= 1'b1;
							end
							OP_DIV: begin
								if (b == '0) begin
									res_q  <= '0;
									dz_q   <= 1'b1;
									done_q <= 1'b1;
								end else begin
									acc_q   <= mag_a;
									opd_q   <= mag_b;
									rem_q   <= '0;
									neg_q   <= a[WORD_W-1] ^ b[WORD_W-1];
									step_q  <= '0;
									state_q <= A_DIV;
								end
							end
							default: begin
								if (b[WORD_W-1]) begin
									// negative exponent: truncated reciprocal
									done_q <= 1'b1;
									if (a == WORD_W'(1)) begin
										res_q <= WORD_W'(1);
									end else if (a == '1) begin
										res_q <= b[0] ? '1 : WORD_W'(1);
									end else if (a == '0) begin
										res_q <= '0;
										dz_q  <= 1'b1;
									end else begin
										res_q <= '0;
									end
								end else begin
									acc_q   <= WORD_W'(1);
									opd_q   <= a;
									ex_q    <= b;
									state_q <= A_POW;
								end
							end
						endcase
					end
				end
				A_DIV: begin
					acc_q  <= quo_n;
					rem_q  <= rem_n;
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						res_q   <= neg_q ? (WORD_W'(0) - quo_n) : quo_n;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				A_POW: begin
					if (ex_q == '0) begin
						res_q   <= acc_q;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						if (ex_q[0]) begin
							acc_q <= mul_acc;
						end
						opd_q <= mul_sq;
						ex_q  <= ex_q >> 1;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.dz   = dz_q;
	assign res      = res_q;

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions streamed one ASCII character per request.
//
//   channel  dir  payload                    when
//   expr     in   ch[7:0], end_of_expr       one character per request
//   result   out  value[31:0], status[1:0]   one request per end mark
//
// Digits return to idle, others pass a flush state; operators then
// read the stack and run the bit-per-cycle divide and square-and-multiply
// loops in the operator unit. End mark: push, top check, emit, output stall.
// One character is in work at a time; expr.ready is high only between them.
// A finished result sits in the output register while the next expression
// is accepted; a new result waits only if that register is still full.
// arst_n clears stack count, pending number and status; no clearing pass.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pee_expr_if.sink      expr,
	pee_result_if.source  result
);

	localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLUSH,
		S_OP,
		S_RD,
		S_ALU,
		S_FIN,
		S_TOP,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [7:0]         ch_q;
	logic               last_q;
	logic [WORD_W-1:0]  pend_q;
	logic               pend_v_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         err_q;
	logic               out_v_q;
	logic [WORD_W-1:0]  value_q;
	logic [1:0]         status_q;

	logic               in_digit;
	logic               is_op;
	logic [WORD_W-1:0]  pend_next;
	logic               full;
	logic               push_en;
	logic               emit_go;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   cnt_m2;
	op_t                op;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic [WORD_W-1:0]  alu_res;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [WORD_W-1:0]  wdata;
	logic [WORD_W-1:0]  rd_a;
	logic [WORD_W-1:0]  rd_b;

	function automatic logic [1:0] sticky(input logic [1:0] cur, input logic [1:0] code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	assign in_digit  = expr.ch inside {[CH_0:CH_9]};
	assign is_op     = ch_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
	assign pend_next = (pend_q << 3) + (pend_q << 1) + {24'd0, expr.ch - CH_0};
	assign full      = cnt_q == CNT_W'(STACK_DEPTH);
	assign push_en   = (state_q == S_FLUSH || state_q == S_FIN) && pend_v_q;
	assign emit_go   = !out_v_q || result.ready;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign cnt_m2    = cnt_q - CNT_W'(2);

	always_comb begin
		case (ch_q)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_POW;
		endcase
	end

	assign alu_req.start = state_q == S_RD;
	assign alu_req.op    = op;

	// operator result replaces the left operand; pushes go to the free slot
	assign we    = (push_en && !full) || (state_q == S_ALU && alu_rsp.done);
	assign waddr = (state_q == S_ALU) ? cnt_m2[ADDR_W-1:0] : cnt_q[ADDR_W-1:0];
	assign wdata = (state_q == S_ALU) ? (alu_rsp.dz ? '0 : alu_res) : pend_q;

	pee_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (cnt_m1[ADDR_W-1:0]),
		.raddr_b (cnt_m2[ADDR_W-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_b),
		.b      (rd_a),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ch_q     <= '0;
			last_q   <= 1'b0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			err_q    <= ST_OK;
			out_v_q  <= 1'b0;
			value_q  <= '0;
			status_q <= ST_OK;
		end else begin
			if (state_q == S_EMIT && emit_go) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (expr.valid) begin
						ch_q   <= expr.ch;
						last_q <= expr.end_of_expr;
						if (in_digit) begin
							pend_q   <= pend_next;
							pend_v_q <= 1'b1;
							state_q  <= expr.end_of_expr ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (pend_v_q) begin
						if (full) begin
							err_q <= sticky(err_q, ST_OVERFLOW);
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						pend_q   <= '0;
						pend_v_q <= 1'b0;
					end
					if (is_op) begin
						state_q <= S_OP;
					end else begin
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_OP: begin
					if (cnt_q < CNT_W'(2)) begin
						err_q   <= sticky(err_q, ST_UNDERFLOW);
						state_q <= last_q ? S_FIN : S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						cnt_q <= cnt_m1;
						if (alu_rsp.dz) begin
							err_q <= sticky(err_q, ST_DIVZERO);
						end
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (pend_v_q) begin
						if (full) begin
							err_q <= sticky(err_q, ST_OVERFLOW);
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						pend_q   <= '0;
						pend_v_q <= 1'b0;
					end
					state_q <= S_TOP;
				end
				S_TOP: begin
					if (cnt_q == '0) begin
						err_q <= sticky(err_q, ST_UNDERFLOW);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						value_q  <= (cnt_q == '0) ? '0 : rd_a;
						status_q <= err_q;
						cnt_q    <= '0;
						err_q    <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign expr.ready    = state_q == S_IDLE;
	assign result.valid  = out_v_q;
	assign result.value  = value_q;
	assign result.status = status_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_alu_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_ALU)
		else $error("operator unit finished outside operator wait");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EMIT && err_q != ST_OK) |=> err_q == $past(err_q))
		else $error("status overwritten within expression");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_go) |=> (cnt_q == '0 && !pend_v_q && out_v_q))
		else $error("state not cleared after result");
`endif

endmodule

@@ tb/sv/tb_postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Streams postfix expressions into the evaluator one character per request
// and checks every result against a cycle-free predictor of the operand
// stack. A short table of directed expressions, some with hand-typed
// results, is followed by random expressions, mostly well formed, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator
	import pee_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EVAL_DEPTH  = 16;
	localparam int unsigned CHAR_BUDGET = 1850;
	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam int unsigned N_CASES     = 23;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [1:0]  status;
	} eval_result_t;

	typedef struct {
		string              txt;
		bit                 typed;
		logic signed [31:0] value;
		logic        [1:0]  status;
	} expr_case_t;

	logic clk;
	logic arst_n;

	pee_expr_if   expr_ch ();
	pee_result_if res_ch ();

	postfix_expression_evaluator #(
		.STACK_DEPTH(EVAL_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.expr  (expr_ch),
		.result(res_ch)
	);

	// predictor state
	logic [31:0]  opnd_stk [EVAL_DEPTH];
	int unsigned  opnd_cnt;
	logic [31:0]  acc_num;
	bit           acc_v;
	logic [1:0]   err_st;
	eval_result_t results_due [$];

	int unsigned mismatches = 0;
	int unsigned chars_sent;
	int unsigned cycle_cnt = 0;
	bit          calm;

	expr_case_t expr_cases [N_CASES] = '{
		'{" ",                  1'b1, 32'h0000_0000, ST_UNDERFLOW},
		'{"4294967295",         1'b1, 32'hFFFF_FFFF, ST_OK},
		'{"2147483647,1+",      1'b1, 32'h8000_0000, ST_OK},
		'{"2,3+4*",             1'b0, 32'h0,         ST_OK},
		'{"9,12-",              1'b1, -32'sd3,       ST_OK},
		'{"0,7-2/",             1'b1, -32'sd3,       ST_OK},
		'{"6,0/",               1'b1, 32'h0000_0000, ST_DIVZERO},
		'{"0,2147483648-0,1-/", 1'b1, 32'h8000_0000, ST_OK},
		'{"2,10^",              1'b1, 32'd1024,      ST_OK},
		'{"0,0^",               1'b1, 32'd1,         ST_OK},
		'{"0,0,1-^",            1'b1, 32'h0000_0000, ST_DIVZERO},
		'{"0,1-0,3-^",          1'b1, 32'hFFFF_FFFF, ST_OK},
		'{"1,0,5-^",            1'b1, 32'd1,         ST_OK},
		'{"7,0,2-^",            1'b1, 32'd0,         ST_OK},
		'{"3,41^",              1'b0, 32'h0,         ST_OK},
		'{"5+",                 1'b1, 32'd5,         ST_UNDERFLOW},
		'{"1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17",
		                        1'b1, 32'd16,        ST_OVERFLOW},
		'{"1+5,0/",             1'b1, 32'd0,         ST_UNDERFLOW},
		'{"12a3\377 +",         1'b1, 32'd15,        ST_OK},
		'{"1,2,3",              1'b1, 32'd3,         ST_OK},
		'{"16,3,2--",           1'b0, 32'h0,         ST_OK},
		'{"+",                  1'b1, 32'd0,         ST_UNDERFLOW},
		'{"99999999999 8,3/*",  1'b0, 32'h0,         ST_OK}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void clear_eval();
		opnd_cnt = 0;
		acc_num  = '0;
		acc_v    = 1'b0;
		err_st   = ST_OK;
	endfunction

	function automatic void flag_err(logic [1:0] code);
		if (err_st == ST_OK)
			err_st = code;
	endfunction

	function automatic void push_opnd(logic [31:0] v);
		if (opnd_cnt >= EVAL_DEPTH) begin
			flag_err(ST_OVERFLOW);
			return;
		end
		opnd_stk[opnd_cnt] = v;
		opnd_cnt++;
	endfunction

	function automatic void flush_acc();
		if (acc_v) begin
			push_opnd(acc_num);
			acc_num = '0;
			acc_v   = 1'b0;
		end
	endfunction

	function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? 32'd0 - a : a;
		mb = b[31] ? 32'd0 - b : b;
		q  = ma / mb;
		return (a[31] != b[31]) ? 32'd0 - q : q;
	endfunction

	function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex,
	                                        output bit dz);
		logic [31:0] acc;
		dz  = 1'b0;
		acc = 32'd1;
		if (ex[31]) begin
			if (base == 32'd1)
				return 32'd1;
			if (base == '1)
				return ex[0] ? '1 : 32'd1;
			if (base == 32'd0)
				dz = 1'b1;
			return 32'd0;
		end
		while (ex != 0) begin
			if (ex[0])
				acc = acc * base;
			base = base * base;
			ex   = ex >> 1;
		end
		return acc;
	endfunction

	function automatic bit to_op(logic [7:0] c, output op_t op);
		op = OP_ADD;
		case (c)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			CH_CARET: op = OP_POW;
			default:  return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void eval_op(op_t op);
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] res;
		bit          dz;
		if (opnd_cnt < 2) begin
			flag_err(ST_UNDERFLOW);
			return;
		end
		rhs      = opnd_stk[opnd_cnt - 1];
		lhs      = opnd_stk[opnd_cnt - 2];
		opnd_cnt = opnd_cnt - 2;
		dz       = 1'b0;
		res      = '0;
		case (op)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = lhs * rhs;
			OP_DIV: begin
				if (rhs == 0)
					dz = 1'b1;
				else
					res = quot_trunc(lhs, rhs);
			end
			default: res = int_pow(lhs, rhs, dz);
		endcase
		if (dz) begin
			flag_err(ST_DIVZERO);
			res = '0;
		end
		push_opnd(res);
	endfunction

	function automatic void track_char(logic [7:0] c, bit last);
		eval_result_t r;
		op_t          op;
		if (c >= CH_0 && c <= CH_9) begin
			acc_num = acc_num * 32'd10 + 32'(c - CH_0);
			acc_v   = 1'b1;
		end else begin
			flush_acc();
			if (to_op(c, op))
				eval_op(op);
		end
		if (last) begin
			flush_acc();
			r.value = '0;
			if (opnd_cnt == 0)
				flag_err(ST_UNDERFLOW);
			else
				r.value = opnd_stk[opnd_cnt - 1];
			r.status = err_st;
			results_due = {results_due, r};
			clear_eval();
		end
	endfunction

	// ---------------- stimulus ----------------

	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 20);
	endfunction

	function automatic logic [7:0] op_char();
		case ($urandom_range(0, 4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			default: return CH_CARET;
		endcase
	endfunction

	function automatic logic [7:0] sep_char();
		return ($urandom_range(0, 9) < 7) ? CH_COMMA : CH_SPACE;
	endfunction

	function automatic string num_text();
		logic [31:0] v;
		string       s;
		v = '0;
		s = "";
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, 9);
			4, 5:       v = $urandom_range(10, 999);
			6, 7:       v = $urandom();
			8: begin
				case ($urandom_range(0, 3))
					0:       v = 32'h0000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'h8000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				// long digit strings wrap the pending number
				repeat ($urandom_range(11, 14))
					s = $sformatf("%s%0d", s, $urandom_range(0, 9));
				return s;
			end
		endcase
		return $sformatf("%0d", v);
	endfunction

	task automatic build_expr(ref logic [7:0] seq [$]);
		int    kind;
		int    n_nums;
		int    depth;
		string txt;
		seq.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 2) == 0)
					seq = {seq, op_char()};
				else
					seq = {seq, 8'($urandom_range(0, 255))};
			end
		end else begin
			n_nums = (kind < 18) ? $urandom_range(14, 19) : $urandom_range(1, 6);
			depth  = 0;
			for (int i = 0; i < n_nums; i++) begin
				txt = num_text();
				for (int j = 0; j < txt.len(); j++)
					seq = {seq, 8'(txt[j])};
				depth++;
				if (depth >= 2 && $urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 1))
						seq = {seq, sep_char()};
					seq = {seq, op_char()};
					depth--;
				end else begin
					seq = {seq, sep_char()};
				end
			end
			while (depth >= 2 && $urandom_range(0, 9) != 0) begin
				seq = {seq, op_char()};
				depth--;
			end
			// a trailing separator is dropped half the time, ending on a digit
			if ((seq[$] == CH_COMMA || seq[$] == CH_SPACE) && $urandom_range(0, 1))
				void'(seq.pop_back());
		end
	endtask

	task automatic send_char(logic [7:0] c, bit last);
		if (idle_now()) begin
			expr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		expr_ch.valid       <= 1'b1;
		expr_ch.ch          <= c;
		expr_ch.end_of_expr <= last;
		do @(posedge clk); while (!(expr_ch.valid && expr_ch.ready));
		track_char(c, last);
		chars_sent++;
		calm = (chars_sent >= 700 && chars_sent < 1000);
	endtask

	// ---------------- result check ----------------

	always @(posedge clk) begin
		eval_result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result value %0d status %0d", $time,
				         res_ch.value, res_ch.status);
			end else begin
				want = results_due.pop_front();
				if (res_ch.value !== want.value) begin
					mismatches++;
					$display("%0t: value expected %0d got %0d", $time,
					         want.value, res_ch.value);
				end
				if (res_ch.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d got %0d", $time,
					         want.status, res_ch.status);
				end
			end
		end
		res_ch.ready <= idle_now() ? 1'b0 : 1'b1;
	end

	initial begin
		logic [7:0]   seq [$];
		eval_result_t typed_r;
		int           n;
		expr_ch.valid       = 1'b0;
		expr_ch.ch          = '0;
		expr_ch.end_of_expr = 1'b0;
		arst_n              = 1'b0;
		chars_sent          = 0;
		calm                = 1'b0;
		clear_eval();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (expr_cases[i]) begin
			n = expr_cases[i].txt.len();
			for (int k = 0; k < n; k++)
				send_char(expr_cases[i].txt[k], k == n - 1);
			if (expr_cases[i].typed) begin
				typed_r.value  = expr_cases[i].value;
				typed_r.status = expr_cases[i].status;
				void'(results_due.pop_back());
				results_due = {results_due, typed_r};
			end
		end

		while (chars_sent < CHAR_BUDGET) begin
			build_expr(seq);
			foreach (seq[k])
				send_char(seq[k], k == seq.size() - 1);
		end
		expr_ch.valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ postfix_expression_evaluator.f @@
rtl/pee_pkg.sv
rtl/pee_if.sv
rtl/pee_stack.sv
rtl/pee_alu.sv
rtl/postfix_expression_evaluator.sv
tb/sv/tb_postfix_expression_evaluator.sv
